// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro samples on the rising edge of clk and is disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define FVSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fvsd check failed");

// Next-cycle implication
`define FVSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fvsd check failed");

`endif

// File: sv/fvsd_pkg.sv
package fvsd_pkg;

  // Encoded byte layout
  localparam logic [7:0] LEADER_MASK = 8'h80;
  localparam logic [7:0] GROUP_MASK  = 8'h7f;

  localparam int GROUP_W   = 7;
  localparam int ACC_W     = 64;
  localparam int VALUE_W   = 63;
  localparam int USED_W    = 4;
  localparam int SHIFT_W   = 7;

  localparam logic [USED_W-1:0]  COUNT_MAX = 4'd15;
  localparam logic [SHIFT_W-1:0] SHIFT_CAP = 7'd120;
  localparam logic [SHIFT_W-1:0] GROUP_STEP = 7'd7;

  // Result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Stream widths
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 72;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_STRAY    = 2'd2
  } err_code_t;

  // One decoded result; value sits in the lowest bits
  typedef struct packed {
    logic                last;
    err_code_t           error_code;
    logic [USED_W-1:0]   bytes_used;
    logic                leader_flag;
    logic [VALUE_W-1:0]  value;
  } result_t;

  // Result slots produced by one byte; slot 1 is used only with slot 0
  typedef struct packed {
    logic valid1;
    logic valid0;
  } push_t;

endpackage

// File: sv/fvsd_in_stage.sv
module fvsd_in_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [fvsd_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                             s_tlast,
  input  logic                             advance,
  output logic                             in_vld,
  output logic [7:0]                       in_byte,
  output logic                             in_eod
);
  import fvsd_pkg::*;

  // Take a new transaction when empty or when the held byte moves on
  assign s_tready = !in_vld || advance;

  // Valid flag of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  // Payload of the input register
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata[7:0];
      in_eod  <= s_tlast;
    end
  end

endmodule

// File: sv/fvsd_decode.sv
module fvsd_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          in_byte,
  input  logic                in_eod,
  output fvsd_pkg::result_t   res0,
  output fvsd_pkg::result_t   res1,
  output fvsd_pkg::push_t     ctl
);
  import fvsd_pkg::*;

  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_next;
  logic [SHIFT_W-1:0] shift;
  logic [SHIFT_W-1:0] shift_next;
  logic               open;
  logic               open_next;
  logic               ovf;
  logic               ovf_next;
  logic [USED_W-1:0]  cnt;
  logic [USED_W-1:0]  cnt_next;

  logic                     leader;
  logic [GROUP_W-1:0]       grp;
  logic [ACC_W+GROUP_W-1:0] placed;
  logic [ACC_W-1:0]         acc_cont;
  logic                     ovf_cont;
  logic [SHIFT_W-1:0]       shift_cont;
  logic [USED_W-1:0]        cnt_cont;
  result_t                  r_open;
  result_t                  r_new;
  result_t                  r_stray;
  result_t                  r_cont;

  assign leader = |(in_byte & LEADER_MASK);
  assign grp    = GROUP_W'(in_byte & GROUP_MASK);

  // Place the continuation group; bits above the accumulator flag overflow
  assign placed = (ACC_W+GROUP_W)'(grp) << shift[5:0];

  always_comb begin
    if (!shift[6]) begin
      acc_cont = acc | placed[ACC_W-1:0];
      ovf_cont = ovf | (|placed[ACC_W+GROUP_W-1:ACC_W]);
    end else begin
      acc_cont = acc;
      ovf_cont = ovf | (|grp);
    end
    shift_cont = (shift <= SHIFT_CAP) ? shift + GROUP_STEP : shift;
    cnt_cont   = (cnt < COUNT_MAX) ? cnt + 4'd1 : cnt;
  end

  // Candidate results
  always_comb begin
    r_open.value       = acc[ACC_W-1:1];
    r_open.leader_flag = acc[0];
    r_open.bytes_used  = cnt;
    r_open.error_code  = ovf ? ERR_OVERFLOW : ERR_OK;
    r_open.last        = !in_eod;

    r_new.value        = VALUE_W'(grp[GROUP_W-1:1]);
    r_new.leader_flag  = grp[0];
    r_new.bytes_used   = 4'd1;
    r_new.error_code   = ERR_OK;
    r_new.last         = 1'b1;

    r_stray.value       = '0;
    r_stray.leader_flag = 1'b0;
    r_stray.bytes_used  = 4'd1;
    r_stray.error_code  = ERR_STRAY;
    r_stray.last        = 1'b1;

    r_cont.value       = acc_cont[ACC_W-1:1];
    r_cont.leader_flag = acc_cont[0];
    r_cont.bytes_used  = cnt_cont;
    r_cont.error_code  = ovf_cont ? ERR_OVERFLOW : ERR_OK;
    r_cont.last        = 1'b1;
  end

  // Select results and next state for this byte
  always_comb begin
    res0       = r_new;
    res1       = r_new;
    ctl        = '0;
    acc_next   = acc;
    shift_next = shift;
    open_next  = open;
    ovf_next   = ovf;
    cnt_next   = cnt;
    if (leader) begin
      res0       = open ? r_open : r_new;
      ctl.valid0 = open || in_eod;
      ctl.valid1 = open && in_eod;
      acc_next   = ACC_W'(grp);
      shift_next = GROUP_STEP;
      open_next  = 1'b1;
      ovf_next   = 1'b0;
      cnt_next   = 4'd1;
    end else if (!open) begin
      res0       = r_stray;
      ctl.valid0 = 1'b1;
    end else begin
      res0       = r_cont;
      ctl.valid0 = in_eod;
      acc_next   = acc_cont;
      shift_next = shift_cont;
      ovf_next   = ovf_cont;
      cnt_next   = cnt_cont;
    end
    // Close the number at end of data
    if (in_eod) begin
      acc_next   = '0;
      shift_next = '0;
      open_next  = 1'b0;
      ovf_next   = 1'b0;
      cnt_next   = '0;
    end
  end

  // Number state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      shift <= '0;
      open  <= 1'b0;
      ovf   <= 1'b0;
      cnt   <= '0;
    end else if (fire) begin
      acc   <= acc_next;
      shift <= shift_next;
      open  <= open_next;
      ovf   <= ovf_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// File: sv/fvsd_out_fifo.sv
module fvsd_out_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  fvsd_pkg::push_t                    push,
  input  fvsd_pkg::result_t                  res0,
  input  fvsd_pkg::result_t                  res1,
  output logic                               room,
  output logic [fvsd_pkg::FIFO_CNT_W-1:0]    level,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [fvsd_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic                               m_tlast
);
  import fvsd_pkg::*;

  result_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] level_next;
  logic [FIFO_CNT_W-1:0] n_push;
  logic                  pop;
  result_t               head;

  assign n_push = FIFO_CNT_W'(push.valid0) + FIFO_CNT_W'(push.valid1);
  assign pop    = m_tvalid && m_tready;
  assign room   = level <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  assign level_next = level + n_push - FIFO_CNT_W'(pop);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(n_push);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      level  <= level_next;
    end
  end

  // Write up to two results per cycle
  always_ff @(posedge clk) begin
    if (push.valid0) begin
      mem[wr_ptr] <= res0;
    end
    if (push.valid1) begin
      mem[wr_ptr + FIFO_PTR_W'(1)] <= res1;
    end
  end

  // Present the oldest result
  assign head     = mem[rd_ptr];
  assign m_tvalid = level != '0;
  assign m_tdata  = {2'b00, head.error_code, head.bytes_used, head.leader_flag, head.value};
  assign m_tlast  = head.last;

endmodule

// File: sv/flagged_varint_stream_decoder_top.sv
// Varint stream decoder: little-endian 7-bit groups, bit 7 set on a leader byte.
// Input channel (s_*): one encoded byte per transaction in s_tdata, with s_tlast
// marking the last byte of the encoded array.
// Output channel (m_*): one decoded number per transaction. A byte causes zero,
// one or two results; m_tlast is high on the final result caused by a byte.
// A number is given out when the next leader byte arrives or on end of data.
// A byte passes the input register, is decoded combinationally and its results
// are written into the result queue, which drives m_tvalid; while the queue
// lacks room the byte waits in the input register.
// Throughput: one byte per cycle while the queue has room. The input register
// holds a byte until the four-entry result queue has two free entries, and the
// queue drains one result per cycle while m_tready is high, so bytes that cause
// two results take longer to drain on the output side.
// Stalls: while m_tready is low the queue fills and then s_tready drops; no
// transaction is lost or repeated.
// Reset (rst, synchronous): clears the queue, the input register and the open
// number; the block takes bytes from the first cycle after reset.
`include "assert_macros.svh"

module flagged_varint_stream_decoder_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [fvsd_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte
  input  logic                               s_tlast,   // end_of_data
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [62:0] value, [63] leader_flag, [67:64] bytes_used, [69:68] error_code,
  // [71:70] zero
  output logic [fvsd_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic                               m_tlast    // last
);
  import fvsd_pkg::*;

  logic                  in_vld;
  logic [7:0]            in_byte;
  logic                  in_eod;
  logic                  advance;
  logic                  room;
  logic [FIFO_CNT_W-1:0] level;
  result_t               res0;
  result_t               res1;
  push_t                 ctl;
  push_t                 push;

  // Move the held byte on when the queue can take both result slots
  assign advance     = in_vld && room;
  assign push.valid0 = ctl.valid0 && advance;
  assign push.valid1 = ctl.valid1 && advance;

  fvsd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (advance),
    .in_vld   (in_vld),
    .in_byte  (in_byte),
    .in_eod   (in_eod)
  );

  fvsd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .in_byte (in_byte),
    .in_eod  (in_eod),
    .res0    (res0),
    .res1    (res1),
    .ctl     (ctl)
  );

  fvsd_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res0     (res0),
    .res1     (res1),
    .room     (room),
    .level    (level),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Second slot only ever follows a first one
  `FVSD_ASSERT_IMP(a_slot_order, ctl.valid1, ctl.valid0)
  // Of two results from one byte only the second carries last
  `FVSD_ASSERT_IMP(a_two_last, push.valid1, !res0.last && res1.last)
  // Queue never fills beyond its depth
  `FVSD_ASSERT_IMP(a_level, 1'b1, level <= FIFO_CNT_W'(FIFO_DEPTH))
  // A byte held back by a queue without two free entries stays in the input register
  `FVSD_ASSERT_NXT(a_hold, in_vld && !room, in_vld && $stable(in_byte))

endmodule
